@@ design/fcr_pkg.sv @@
// Shared types, constants and byte-class helpers for the framed command receiver.
// Depends on nothing; every other design file imports it.

package fcr_pkg;

  localparam logic [7:0] START_BYTE    = 8'h24;  // '$'
  localparam logic [7:0] END_BYTE      = 8'h23;  // '#'
  localparam logic [7:0] RESET_MAX_LEN = 8'd108;
  localparam logic [8:0] MIN_LEN_LIMIT = 9'd8;
  localparam int unsigned HDR_BYTES    = 7;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UP_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LOW_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_LOW_Z = 8'h7A;  // 'z'
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_R     = 8'h52;

  // Configuration register indexes (byte address is four times the index).
  localparam logic REG_MAX_FRAME_LEN = 1'b0;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_UNKNOWN      = 3'd1,
    ST_BAD_FRAME    = 3'd2,
    ST_BAD_CHECKSUM = 3'd3,
    ST_TOO_LONG     = 3'd4,
    ST_TOO_SHORT    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_BFF = 2'd0,
    CMD_BFL = 2'd1,
    CMD_IDX = 2'd2,
    CMD_CLR = 2'd3
  } cmd_t;

  typedef struct packed {
    status_t    status;
    logic [1:0] command_code;
  } result_t;

  // Header bytes at frame positions 1..7; entry 0 is position 1.
  typedef logic [HDR_BYTES-1:0][7:0] hdr_t;

  typedef struct packed {
    logic       receiving;
    logic [7:0] frame_len;
  } trk_status_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } buf_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LOW_A) && (c <= CH_LOW_Z));
  endfunction

endpackage

@@ design/fcr_if.sv @@
// Handshake interfaces for the receive byte channel and the result channel.
// Depends on fcr_pkg for the result status type.

interface fcr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fcr_result_if
  import fcr_pkg::*;
;
  logic       valid;
  logic       ready;
  status_t    status;
  logic [1:0] command_code;

  modport source (output valid, output status, output command_code, input ready);
  modport sink (input valid, input status, input command_code, output ready);
endinterface

@@ design/fcr_cfg_regs.sv @@
// APB-style configuration register block holding the frame length limit.
// Depends on fcr_pkg for the reset value and register index.

module fcr_cfg_regs
  import fcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  max_frame_len
);

  logic [7:0] max_len_r;
  logic [7:0] max_len_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_FRAME_LEN);

  always_comb begin
    max_len_nxt = max_len_r;
    if (wr_en) begin
      max_len_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= RESET_MAX_LEN;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_MAX_FRAME_LEN) begin
      prdata = {24'd0, max_len_r};
    end
  end

  assign max_frame_len = max_len_r;

endmodule

@@ design/fcr_judge.sv @@
// Combinational verdict on a closed frame from its seven stored header bytes.
// Depends on fcr_pkg for status codes, command codes and byte-class helpers.

module fcr_judge
  import fcr_pkg::*;
(
  input  hdr_t    hdr,
  output result_t verdict
);

  logic       hdr_bad;
  logic       digits_ok;
  logic       letters_ok;
  logic [7:0] digits_value;
  logic [7:0] letter_sum;
  logic [3:0] d_hund;
  logic [3:0] d_tens;
  logic [3:0] d_ones;

  always_comb begin
    hdr_bad = 1'b0;
    for (int i = 0; i < HDR_BYTES; i++) begin
      if ((hdr[i] == 8'd0) || (hdr[i] == END_BYTE)) begin
        hdr_bad = 1'b1;
      end
    end
  end

  assign digits_ok  = is_digit(hdr[3]) && is_digit(hdr[4]) && is_digit(hdr[5]);
  assign letters_ok = is_letter(hdr[0]) && is_letter(hdr[1]) && is_letter(hdr[2]);

  assign d_hund = 4'(hdr[3] - CH_ZERO);
  assign d_tens = 4'(hdr[4] - CH_ZERO);
  assign d_ones = 4'(hdr[5] - CH_ZERO);

  // Both sides are kept modulo 256 by the 8-bit result width.
  assign digits_value = 8'(({4'd0, d_hund} * 8'd100) + ({4'd0, d_tens} * 8'd10)
                           + {4'd0, d_ones});
  assign letter_sum   = 8'(hdr[0] + hdr[1] + hdr[2]);

  always_comb begin
    verdict.status       = ST_UNKNOWN;
    verdict.command_code = CMD_BFF;
    if (hdr_bad || !digits_ok) begin
      verdict.status = ST_BAD_FRAME;
    end else if (letter_sum != digits_value) begin
      verdict.status = ST_BAD_CHECKSUM;
    end else if (!letters_ok) begin
      verdict.status = ST_BAD_FRAME;
    end else if ((hdr[0] == CH_B) && (hdr[1] == CH_F) && (hdr[2] == CH_F)) begin
      verdict.status = ST_OK;
      verdict.command_code = CMD_BFF;
    end else if ((hdr[0] == CH_B) && (hdr[1] == CH_F) && (hdr[2] == CH_L)) begin
      verdict.status = ST_OK;
      verdict.command_code = CMD_BFL;
    end else if ((hdr[0] == CH_I) && (hdr[1] == CH_D) && (hdr[2] == CH_X)) begin
      verdict.status = ST_OK;
      verdict.command_code = CMD_IDX;
    end else if ((hdr[0] == CH_C) && (hdr[1] == CH_L) && (hdr[2] == CH_R)) begin
      verdict.status = ST_OK;
      verdict.command_code = CMD_CLR;
    end
  end

endmodule

@@ design/fcr_frame_tracker.sv @@
// Frame state per accepted byte: in-frame flag, length count and header capture.
// Depends on fcr_pkg and on fcr_judge for the end-of-frame verdict.

module fcr_frame_tracker
  import fcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  max_frame_len,
  output logic        res_valid,
  output result_t     res,
  output trk_status_t status
);

  logic       receiving_r, receiving_nxt;
  logic [7:0] len_r, len_nxt;
  hdr_t       hdr_r, hdr_nxt;

  logic       is_start;
  logic       in_frame;
  logic [7:0] len_eff;
  logic [8:0] next_len;
  result_t    verdict;

  fcr_judge u_judge (
    .hdr     (hdr_r),
    .verdict (verdict)
  );

  assign is_start = (rx_byte == START_BYTE);
  assign in_frame = is_start || receiving_r;
  assign len_eff  = is_start ? 8'd0 : len_r;
  assign next_len = {1'b0, len_eff} + 9'd1;

  always_comb begin
    receiving_nxt = receiving_r;
    len_nxt       = len_r;
    hdr_nxt       = hdr_r;
    res_valid     = 1'b0;
    res.status       = ST_OK;
    res.command_code = CMD_BFF;
    if (accept && in_frame) begin
      receiving_nxt = 1'b1;
      for (int i = 0; i < HDR_BYTES; i++) begin
        if (len_eff == 8'(i + 1)) begin
          hdr_nxt[i] = rx_byte;
        end
      end
      if (next_len > {1'b0, max_frame_len}) begin
        receiving_nxt = 1'b0;
        len_nxt       = 8'd0;
        res_valid     = 1'b1;
        res.status    = ST_TOO_LONG;
      end else begin
        len_nxt = next_len[7:0];
        if (rx_byte == END_BYTE) begin
          res_valid = 1'b1;
          if (next_len <= MIN_LEN_LIMIT) begin
            // The frame stays open after a too-short end marker.
            res.status = ST_TOO_SHORT;
          end else begin
            // The header is complete here; the end marker itself is not stored.
            res           = verdict;
            receiving_nxt = 1'b0;
            len_nxt       = 8'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      len_r       <= 8'd0;
    end else begin
      receiving_r <= receiving_nxt;
      len_r       <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

  assign status.receiving = receiving_r;
  assign status.frame_len = len_r;

endmodule

@@ design/fcr_out_buf.sv @@
// Two-entry result buffer: output register plus a skid register behind it.
// Depends on fcr_pkg for the result type.

module fcr_out_buf
  import fcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  result_t     push_data,
  output logic        can_accept,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data,
  output buf_status_t status
);

  logic    main_v_r, main_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t main_d_r, main_d_nxt;
  result_t skid_d_r, skid_d_nxt;
  logic    main_free;

  // The skid entry absorbs one result while the output register is stalled.
  assign can_accept = !skid_v_r;
  assign main_free  = !main_v_r || out_ready;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_d_nxt = main_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (main_free) begin
        main_v_nxt = 1'b1;
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (main_free) begin
        main_v_nxt = 1'b1;
        main_d_nxt = push_data;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = push_data;
      end
    end else if (out_ready) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid         = main_v_r;
  assign out_data          = main_d_r;
  assign status.main_valid = main_v_r;
  assign status.skid_valid = skid_v_r;

endmodule

@@ design/framed_command_receiver.sv @@
// Top level of the framed command receiver: byte tracker, result buffer, config.
// Depends on fcr_pkg, fcr_if, fcr_cfg_regs, fcr_frame_tracker and fcr_out_buf.
//
//   Channel   Direction  Payload                         Handshake
//   in_ch     sink       rx_byte[7:0]                    valid/ready
//   out_ch    source     status[2:0], command_code[1:0]  valid/ready
//   cfg_*     slave      max_frame_len at byte addr 0    APB, pready tied high
//
// One byte is taken every cycle while in_ch.ready is high; its result, if any, is held
// in the output buffer's main register (via the skid register while out_ch stalls).
// rst_n is synchronous: the receiver leaves any frame and the limit returns to 108.
// A stalled out_ch is absorbed by a one-entry skid register, so in_ch drops ready
// only once two results wait.

module framed_command_receiver
  import fcr_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  fcr_byte_if.sink      in_ch,
  fcr_result_if.source  out_ch,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  logic        accept;
  logic        can_accept;
  logic        res_valid;
  result_t     res;
  result_t     out_data;
  logic [7:0]  max_frame_len;
  trk_status_t trk_status;
  buf_status_t buf_status;

  fcr_cfg_regs u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .max_frame_len (max_frame_len)
  );

  assign in_ch.ready = can_accept;
  assign accept      = in_ch.valid && can_accept;

  fcr_frame_tracker u_trk (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .rx_byte       (in_ch.rx_byte),
    .max_frame_len (max_frame_len),
    .res_valid     (res_valid),
    .res           (res),
    .status        (trk_status)
  );

  fcr_out_buf u_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (can_accept),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_data),
    .status     (buf_status)
  );

  assign out_ch.status       = out_data.status;
  assign out_ch.command_code = out_data.command_code;

  // The skid entry is only ever filled behind a held output register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    buf_status.skid_valid |-> buf_status.main_valid)
    else $error("skid entry valid while output register empty");

  // Outside a frame the length count is always cleared.
  a_idle_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !trk_status.receiving |-> (trk_status.frame_len == 8'd0))
    else $error("frame length nonzero outside a frame");

  // Any status other than ok carries a zero command code.
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != ST_OK)) |-> (out_ch.command_code == CMD_BFF))
    else $error("command code set on a failing status");

  // A result pushed while the output stalls must land in the skid entry.
  a_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && accept && buf_status.main_valid && !out_ch.ready)
      |=> buf_status.skid_valid)
    else $error("result lost while output stalled");

endmodule
